// ----- design/assert_macros.svh -----
// Assertion macros shared by the Sobel gradient design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SGM_ASSERT_NEVER(lbl, cond, msg) \
  `SGM_ASSERT(lbl, !(cond), msg)
`else
`define SGM_ASSERT(lbl, prop, msg)
`define SGM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/sgm_pkg.sv -----
// Shared types, constants and kernel function for the Sobel gradient block.
`timescale 1ns / 1ps
package sgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int POS_W      = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_MIN    = 3;

  localparam logic [CFG_DATA_W-1:0] IMG_W_RESET = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] IMG_H_RESET = CFG_DATA_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Row-major 3x3: top-left .. bottom-right.
  localparam logic signed [2:0] SOBEL_KX [9] = '{
    -3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1
  };
  localparam logic signed [2:0] SOBEL_KY [9] = '{
    -3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1
  };

  typedef logic [8:0][PIX_W-1:0] nbhd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  function automatic logic signed [GRAD_W-1:0] sobel_sum(input nbhd_t nb, input logic use_y);
    logic signed [GRAD_W-1:0] acc;
    logic signed [GRAD_W-1:0] coef;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      coef = use_y ? GRAD_W'(SOBEL_KY[i]) : GRAD_W'(SOBEL_KX[i]);
      acc  = acc + GRAD_W'(coef * $signed(GRAD_W'({1'b0, nb[i]})));
    end
    return acc;
  endfunction

endpackage

// ----- design/sgm_if.sv -----
// Stream interfaces for pixel input beats and gradient result beats.
`timescale 1ns / 1ps
interface sgm_pix_if;
  import sgm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sgm_res_if;
  import sgm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic [POS_W-1:0]         centre_row;
  logic [POS_W-1:0]         centre_col;
  logic                     frame_end;
  modport source (
    output valid, output grad_x, output grad_y, output magnitude,
    output centre_row, output centre_col, output frame_end, input ready
  );
  modport sink (
    input valid, input grad_x, input grad_y, input magnitude,
    input centre_row, input centre_col, input frame_end, output ready
  );
endinterface

// ----- design/sgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sgm_isqrt.sv -----
// Squaring stage and iterative integer square root of gx^2 + gy^2.
`timescale 1ns / 1ps
module sgm_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [sgm_pkg::GRAD_W-1:0] gx_i,
  input  logic signed [sgm_pkg::GRAD_W-1:0] gy_i,
  output sgm_pkg::root_stat_t              stat_o,
  output logic [sgm_pkg::MAG_W-1:0]        root_o
);
  import sgm_pkg::*;

  localparam int SQ_W = 2 * GRAD_W;
  localparam int V_W  = SQ_W;

  typedef enum logic [3:0] {
    R_IDLE   = 4'b0001,
    R_SQUARE = 4'b0010,
    R_SUM    = 4'b0100,
    R_ITER   = 4'b1000
  } root_state_e;

  root_state_e state_q, state_d;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic [SQ_W-1:0] sqx_q, sqy_q;
  logic [V_W-1:0]  v_q, res_q, bit_q;
  logic [V_W-1:0]  trial;
  logic signed [SQ_W-1:0] gx_ext, gy_ext;
  logic done_q, done_d;

  assign gx_ext = SQ_W'(gx_q);
  assign gy_ext = SQ_W'(gy_q);
  assign trial  = res_q + bit_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      R_IDLE:   if (start_i) state_d = R_SQUARE;
      R_SQUARE: state_d = R_SUM;
      R_SUM:    state_d = R_ITER;
      R_ITER: begin
        if (bit_q[0]) begin
          state_d = R_IDLE;
          done_d  = 1'b1;
        end
      end
      default:  state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == R_IDLE && start_i) begin
      gx_q <= gx_i;
      gy_q <= gy_i;
    end
    if (state_q == R_SQUARE) begin
      sqx_q <= SQ_W'(gx_ext * gx_ext);
      sqy_q <= SQ_W'(gy_ext * gy_ext);
    end
    if (state_q == R_SUM) begin
      v_q   <= sqx_q + sqy_q;
      res_q <= '0;
      bit_q <= V_W'(1) << (2 * (MAG_W - 1));
    end
    if (state_q == R_ITER) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign stat_o.busy = (state_q != R_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = res_q[MAG_W-1:0];

endmodule

// ----- design/sobel_gradient_magnitude.sv -----
// Top level: line stores, 3x3 window, sequencing and result register.
// An accepted pixel is read against both line stores (registered RAM read) and
// written back the next cycle. A border pixel is done once written back; an
// interior pixel then passes through the squaring stage and the eleven-step
// square-root iteration to a loaded result, plus any wait for
// the result register to drain. One pixel is in flight at a time; a new pixel
// is taken while an earlier result still waits in the output register. Line
// stores need no clearing after reset: each frame writes two full rows before
// any stored pixel reaches a result. Writing image_width or image_height
// restarts the frame at row 0, column 0; values are clamped to 3..MAX.
`timescale 1ns / 1ps
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sgm_pix_if.sink                          pix_i,
  sgm_res_if.source                        res_o
);
  import sgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_ROOT  = 4'b0100,
    S_PUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;
  logic [CW-1:0] col_q, col_d, last_col;
  logic [RW-1:0] row_q, row_d, last_row;
  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] rd_a, rd_b;
  nbhd_t nb;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [POS_W-1:0] crow_q, ccol_q;
  logic fend_q;
  logic accept, fetch, interior, root_start, out_free, out_load, cfg_hit;
  root_stat_t root_stat;
  logic [MAG_W-1:0] root;
  logic out_valid_q;
  logic signed [GRAD_W-1:0] out_gx_q, out_gy_q;
  logic [MAG_W-1:0] out_mag_q;
  logic [POS_W-1:0] out_row_q, out_col_q;
  logic out_fend_q;

  always_comb begin
    if (cfg_w_q < CFG_DATA_W'(DIM_MIN)) begin
      last_col = CW'(DIM_MIN - 1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(cfg_w_q - CFG_DATA_W'(1));
    end
    if (cfg_h_q < CFG_DATA_W'(DIM_MIN)) begin
      last_row = RW'(DIM_MIN - 1);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(cfg_h_q - CFG_DATA_W'(1));
    end
  end

  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign fetch       = (state_q == S_FETCH);
  assign interior    = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign root_start  = fetch && interior;
  assign out_free    = !out_valid_q || res_o.ready;
  assign out_load    = (state_q == S_PUSH) && out_free;
  assign cfg_hit     = cfg_we_i &&
                       (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);

  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (fetch),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .raddr_i (col_q),
    .rdata_o (rd_a)
  );

  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (fetch),
    .waddr_i (col_q),
    .wdata_i (rd_a),
    .raddr_i (col_q),
    .rdata_o (rd_b)
  );

  assign nb = {pix_q, win_q[5], win_q[2], rd_a, win_q[4], win_q[1], rd_b, win_q[3], win_q[0]};
  assign gx_d = sobel_sum(nb, 1'b0);
  assign gy_d = sobel_sum(nb, 1'b1);

  sgm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .gx_i    (gx_d),
    .gy_i    (gy_d),
    .stat_o  (root_stat),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_FETCH;
      S_FETCH: state_d = interior ? S_ROOT : S_IDLE;
      S_ROOT:  if (root_stat.done) state_d = S_PUSH;
      S_PUSH:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (fetch) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end else begin
      col_d = col_q;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_w_q     <= IMG_W_RESET;
      cfg_h_q     <= IMG_H_RESET;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_HEIGHT) begin
        cfg_h_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_i.pixel;
    end
    if (fetch) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= rd_b;
      win_q[4] <= rd_a;
      win_q[5] <= pix_q;
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      crow_q   <= POS_W'(32'(row_q) - 32'd1);
      ccol_q   <= POS_W'(32'(col_q) - 32'd1);
      fend_q   <= (row_q == last_row) && (col_q == last_col);
    end
    if (out_load) begin
      out_gx_q   <= gx_q;
      out_gy_q   <= gy_q;
      out_mag_q  <= root;
      out_row_q  <= crow_q;
      out_col_q  <= ccol_q;
      out_fend_q <= fend_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.grad_x     = out_gx_q;
  assign res_o.grad_y     = out_gy_q;
  assign res_o.magnitude  = out_mag_q;
  assign res_o.centre_row = out_row_q;
  assign res_o.centre_col = out_col_q;
  assign res_o.frame_end  = out_fend_q;

`include "assert_macros.svh"

  `SGM_ASSERT(a_one_in_flight, accept |=> !pix_i.ready, "pixel taken while one in flight")
  `SGM_ASSERT_NEVER(a_root_overlap, root_start && root_stat.busy, "root unit restarted busy")
  `SGM_ASSERT(a_pos_range, (col_q <= last_col) && (row_q <= last_row), "position out of frame")
  `SGM_ASSERT(a_load_from_push, $rose(res_o.valid) |-> $past(state_q == S_PUSH),
              "result raised outside push")

endmodule

// ----- sim/tb.sv -----
// Testbench for the Sobel gradient block: directed and random raster frames checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import sgm_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_GUARD   = 20_000;
  localparam int RANDOM_PIXELS = 100;
  localparam int MAX_PRINTS    = 40;
  localparam int LONG_HOLD     = 300;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_RAMP} pix_mode_e;
  typedef enum int {EDGE_VERTICAL, EDGE_HORIZONTAL, EDGE_CHECKER} edge_pattern_e;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     fend;
  } grad_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sgm_pix_if pix ();
  sgm_res_if res ();

  sobel_gradient_magnitude dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  logic [PIX_W-1:0]      row_above     [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      row_two_above [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      win_cols      [6];
  int unsigned           next_row;
  int unsigned           next_col;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  grad_beat_t            grad_expected [$];

  int errors = 0;
  int cycle_count = 0;
  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int hold_request = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void clear_window_state();
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      row_above[i] = '0;
      row_two_above[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    next_row = 0;
    next_col = 0;
    width_reg = IMG_W_RESET;
    height_reg = IMG_H_RESET;
  endfunction

  function automatic void sobel_predict(input logic [PIX_W-1:0] bot);
    int unsigned w, h, r, c, sq;
    int tl, ml, bl, tm, bm, tr, mr, br, gx, gy;
    logic [PIX_W-1:0] top, mid;
    grad_beat_t b;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    r = next_row;
    c = next_col;
    top = row_two_above[c];
    mid = row_above[c];
    row_two_above[c] = mid;
    row_above[c] = bot;
    if (r >= 2 && c >= 2) begin
      tl = win_cols[0];
      ml = win_cols[1];
      bl = win_cols[2];
      tm = win_cols[3];
      bm = win_cols[5];
      tr = top;
      mr = mid;
      br = bot;
      gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
      gy = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
      sq = gx * gx + gy * gy;
      b.gx = GRAD_W'(gx);
      b.gy = GRAD_W'(gy);
      b.mag = MAG_W'(root_floor(sq));
      b.row = POS_W'(r - 1);
      b.col = POS_W'(c - 1);
      b.fend = (r == h - 1) && (c == w - 1);
      grad_expected.push_back(b);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = bot;
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_e mode, input int idx);
    case (mode)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_RAMP:    return PIX_W'(idx * 13 + $urandom_range(0, 31));
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] edge_pixel(input edge_pattern_e pat, input int r,
                                                  input int c);
    case (pat)
      EDGE_VERTICAL:   return (c == 2) ? 8'hFF : 8'h00;
      EDGE_HORIZONTAL: return (r == 0) ? 8'hFF : ((r == 1) ? 8'h80 : 8'h00);
      default:         return ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // All tasks below start and end on a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
      next_row = 0;
      next_col = 0;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
      next_row = 0;
      next_col = 0;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = sender_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    do @(posedge clk_i); while (!pix.ready);
    sobel_predict(p);
    @(negedge clk_i);
  endtask

  task automatic send_run(input int count, input pix_mode_e mode);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(mode, i));
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    pix.valid <= 1'b0;
    while (grad_expected.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk_i);
      guard++;
    end
    if (grad_expected.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", grad_expected.size()));
      grad_expected.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_beat
    grad_beat_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (grad_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                  res.centre_row, res.centre_col));
      end else begin
        want = grad_expected.pop_front();
        if (res.grad_x !== want.gx)
          report_mismatch($sformatf("grad_x %0d, want %0d at row %0d col %0d",
                                    res.grad_x, want.gx, want.row, want.col));
        if (res.grad_y !== want.gy)
          report_mismatch($sformatf("grad_y %0d, want %0d at row %0d col %0d",
                                    res.grad_y, want.gy, want.row, want.col));
        if (res.magnitude !== want.mag)
          report_mismatch($sformatf("magnitude %0d, want %0d at row %0d col %0d",
                                    res.magnitude, want.mag, want.row, want.col));
        if (res.centre_row !== want.row)
          report_mismatch($sformatf("centre_row %0d, want %0d", res.centre_row, want.row));
        if (res.centre_col !== want.col)
          report_mismatch($sformatf("centre_col %0d, want %0d", res.centre_col, want.col));
        if (res.frame_end !== want.fend)
          report_mismatch($sformatf("frame_end %0b, want %0b at row %0d col %0d",
                                    res.frame_end, want.fend, want.row, want.col));
      end
    end
  end

  initial begin : result_sink
    int wait_n;
    int hold_n;
    res.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_request > 0) begin
        hold_n = hold_request;
        hold_request = 0;
        res.ready <= 1'b0;
        repeat (hold_n) @(negedge clk_i);
      end
      wait_n = receiver_idle ? $urandom_range(0, 19) : 0;
      if (wait_n > 0) begin
        res.ready <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (res.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  task automatic test_reset_geometry();
    sender_idle = 1'b0;
    receiver_idle = 1'b1;
    send_run(2 * 640 + 12, PIX_UNIFORM);
    drain_results();
  endtask

  task automatic test_min_frames();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (int k = EDGE_VERTICAL; k <= EDGE_CHECKER; k++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          send_pixel(edge_pixel(edge_pattern_e'(k), r, c));
    drain_results();
  endtask

  task automatic test_register_edges();
    sender_idle = 1'b1;
    receiver_idle = 1'b0;
    set_geometry(CFG_DATA_W'(1), CFG_DATA_W'(2));
    send_run(9, PIX_EXTREME);
    send_run(4, PIX_UNIFORM);
    drain_results();
    write_reg(REG_UNUSED_2, CFG_DATA_W'($urandom_range(0, 2047)));
    write_reg(REG_UNUSED_3, CFG_DATA_W'($urandom_range(0, 2047)));
    send_run(5, PIX_UNIFORM);
    send_run(4, PIX_UNIFORM);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    send_run(9, PIX_UNIFORM);
    drain_results();
  endtask

  task automatic test_large_frames();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    set_geometry(CFG_DATA_W'(2047), CFG_DATA_W'(3));
    send_run(40, PIX_UNIFORM);
    drain_results();
    set_geometry(CFG_DATA_W'(0), CFG_DATA_W'(DEF_MAX_HEIGHT));
    send_run(40, PIX_RAMP);
    drain_results();
    set_geometry(CFG_DATA_W'(5), CFG_DATA_W'(2047));
    send_run(40, PIX_EXTREME);
    drain_results();
  endtask

  task automatic test_backpressure();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    set_geometry(CFG_DATA_W'(8), CFG_DATA_W'(6));
    hold_request = LONG_HOLD;
    send_run(2 * 8 * 6, PIX_UNIFORM);
    drain_results();
  endtask

  task automatic test_random_frames();
    int sent, pick, w, h, frames, extra, count;
    logic [CFG_DATA_W-1:0] w_raw, h_raw;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) w_raw = CFG_DATA_W'($urandom_range(13, 48));
      else if (pick == 1) w_raw = CFG_DATA_W'($urandom_range(0, 3));
      else w_raw = CFG_DATA_W'($urandom_range(3, 12));
      if ($urandom_range(0, 7) == 0) h_raw = CFG_DATA_W'($urandom_range(0, 3));
      else h_raw = CFG_DATA_W'($urandom_range(3, 8));
      pick = $urandom_range(0, 5);
      if (pick == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                  CFG_DATA_W'($urandom_range(0, 2047)));
      if (pick != 1) write_reg(REG_IMAGE_WIDTH, w_raw);
      if (pick != 2) write_reg(REG_IMAGE_HEIGHT, h_raw);
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2 * w) : 0;
      count = frames * w * h + extra;
      sender_idle = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      send_run(count, pix_mode_e'($urandom_range(0, 2)));
      sent += count;
      drain_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    clear_window_state();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_min_frames();
    test_register_edges();
    test_large_frames();
    test_backpressure();
    test_random_frames();

    drain_results();
    if (grad_expected.size() != 0)
      report_mismatch($sformatf("%0d expected beats left over", grad_expected.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sgm_pkg.sv
design/sgm_if.sv
design/sgm_ram.sv
design/sgm_isqrt.sv
design/sobel_gradient_magnitude.sv
sim/tb.sv
